// ----- hdl/dsq_pkg.sv -----
// Package with sizes, operation and status codes, the sequencer state type and the request and response types.
package dsq_pkg;
   localparam int DEPTH = 16;
   localparam int KEY_BITS = 32;
   localparam int PRIORITY_BITS = 16;
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_PEEK = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_DUP = 2'd1,
      ST_FULL = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [KEY_BITS-1:0] key_in;
      logic [PRIORITY_BITS-1:0] priority_in;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key_out;
      logic [1:0] status;
      logic empty_res;
      logic full_res;
   } rsp_type;
endpackage

// ----- hdl/dsq_if.sv -----
// Valid and ready channel interface that carries one payload item.
interface dsq_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/dedup_sorted_priority_queue.sv -----
// Top level of the sorted priority queue with duplicate suppression.
// A sequencer over one entry memory with registered reads handles one item at a time.
// Steps from acceptance to a valid result: an enqueue searches the entries, then moves later
// entries up one slot and writes the new one; a dropped enqueue ends after the search.
// Dequeue reads the head and shifts the rest down, peek reads the head, clear resets the count.
// The next item can be accepted once the result is presented; reset clears the count, not the memory.
module dedup_sorted_priority_queue (
   input logic clock,
   input logic reset,
   dsq_if.sink req,
   dsq_if.source rsp
);
   import dsq_pkg::*;

   logic [KEY_BITS+PRIORITY_BITS-1:0] mem [DEPTH];
   logic [IDX_BITS-1:0] raddr, waddr;
   logic [KEY_BITS+PRIORITY_BITS-1:0] rdata_ff, wdata;
   logic we;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in, pos_ff, pos_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic phase_ff, phase_in, dup_ff, dup_in;
   req_type cur_ff, cur_in;
   rsp_type work_ff, work_in;
   rsp_type res_ff, res_in;
   logic rvalid_ff, rvalid_in;

   logic [KEY_BITS-1:0] rkey;
   logic [PRIORITY_BITS-1:0] rpri;
   assign rkey = rdata_ff[KEY_BITS+PRIORITY_BITS-1:PRIORITY_BITS];
   assign rpri = rdata_ff[PRIORITY_BITS-1:0];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rvalid_ff;
   assign rsp.payload = res_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      phase_in = phase_ff;
      dup_in = dup_ff;
      cur_in = cur_ff;
      work_in = work_ff;
      res_in = res_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      raddr = idx_ff[IDX_BITS-1:0];
      waddr = idx_ff[IDX_BITS-1:0];
      wdata = rdata_ff;
      we = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cur_in = req.payload;
               idx_in = '0;
               phase_in = 1'b0;
               dup_in = 1'b0;
               pos_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Phase 0 issues a read, phase 1 inspects its data.
            if (!phase_ff) begin
               raddr = idx_ff[IDX_BITS-1:0];
               if (cur_ff.kind == OP_CLEAR) begin
                  count_in = '0;
                  work_in.key_out = '0;
                  work_in.status = ST_OK;
                  state_in = S_DONE;
               end else if (idx_ff == count_ff) begin
                  work_in.key_out = '0;
                  if (cur_ff.kind != OP_ENQ) begin
                     work_in.status = ST_EMPTY;
                     state_in = S_DONE;
                  end else if (dup_ff) begin
                     work_in.status = ST_DUP;
                     state_in = S_DONE;
                  end else if (count_ff == CNT_BITS'(DEPTH)) begin
                     work_in.status = ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     pos_in = idx_ff;
                     idx_in = count_ff;
                     state_in = S_SHIFT_UP;
                  end
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               phase_in = 1'b0;
               if (cur_ff.kind != OP_ENQ) begin
                  work_in.key_out = rkey;
                  work_in.status = ST_OK;
                  if (cur_ff.kind == OP_DEQ) begin
                     idx_in = '0;
                     state_in = S_SHIFT_DOWN;
                  end else state_in = S_DONE;
               end else begin
                  if (idx_ff == '0 && cur_ff.priority_in > rpri && rkey == cur_ff.key_in)
                     dup_in = 1'b1;
                  if (rpri >= cur_ff.priority_in) begin
                     if (rkey == cur_ff.key_in) dup_in = 1'b1;
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     work_in.key_out = '0;
                     if (dup_ff || rkey == cur_ff.key_in && idx_ff == '0
                         && cur_ff.priority_in > rpri) begin
                        work_in.status = ST_DUP;
                        state_in = S_DONE;
                     end else if (count_ff == CNT_BITS'(DEPTH)) begin
                        work_in.status = ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        pos_in = idx_ff;
                        idx_in = count_ff;
                        state_in = S_SHIFT_UP;
                     end
                  end
               end
            end
         end
         S_SHIFT_UP: begin
            // idx is the slot to fill; copy slot idx-1 into it.
            if (idx_ff == pos_ff) begin
               we = 1'b1;
               waddr = idx_ff[IDX_BITS-1:0];
               wdata = {cur_ff.key_in, cur_ff.priority_in};
               count_in = count_ff + 1'b1;
               work_in.status = ST_OK;
               state_in = S_DONE;
            end else if (!phase_ff) begin
               raddr = IDX_BITS'(idx_ff - 1'b1);
               phase_in = 1'b1;
            end else begin
               we = 1'b1;
               waddr = idx_ff[IDX_BITS-1:0];
               idx_in = idx_ff - 1'b1;
               phase_in = 1'b0;
            end
         end
         S_SHIFT_DOWN: begin
            if (idx_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else if (!phase_ff) begin
               raddr = IDX_BITS'(idx_ff + 1'b1);
               phase_in = 1'b1;
            end else begin
               we = 1'b1;
               waddr = idx_ff[IDX_BITS-1:0];
               idx_in = idx_ff + 1'b1;
               phase_in = 1'b0;
            end
         end
         S_DONE: begin
            if (!rvalid_ff || rsp.ready) begin
               res_in = work_ff;
               res_in.empty_res = (count_ff == '0);
               res_in.full_res = (count_ff == CNT_BITS'(DEPTH));
               rvalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rvalid_ff <= rvalid_in;
      end
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      phase_ff <= phase_in;
      dup_ff <= dup_in;
      cur_ff <= cur_in;
      work_ff <= work_in;
      res_ff <= res_in;
   end
endmodule

// ----- hdl/dsq_checker.sv -----
// Port-level checker for the priority queue and its bind statement.
module dsq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status,
   input logic [dsq_pkg::KEY_BITS-1:0] rsp_key_out,
   input logic rsp_empty_res,
   input logic rsp_full_res
);
   import dsq_pkg::*;

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_empty_res && rsp_full_res)) else $error("empty and full");
   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_key_out == '0 && rsp_empty_res)
      else $error("empty result");
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_full_res) else $error("full drop");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_out))
      else $error("result dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second item accepted");
endmodule

bind dedup_sorted_priority_queue dsq_checker u_dsq_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.payload.status), .rsp_key_out(rsp.payload.key_out),
   .rsp_empty_res(rsp.payload.empty_res), .rsp_full_res(rsp.payload.full_res)
);

// ----- tb/sv/tb_dsq_pkg_stub.sv -----
// Helper types for the priority queue testbench.
`timescale 1ns / 1ps
package tb_dsq_types;
   import dsq_pkg::*;
   typedef struct {
      logic [KEY_BITS-1:0] key;
      logic [PRIORITY_BITS-1:0] prio;
   } slot_type;
endpackage

// ----- tb/sv/tb.sv -----
// Testbench for the sorted priority queue: random and directed operations with a predictor.
`timescale 1ns / 1ps
module tb;
   import dsq_pkg::*;
   import tb_dsq_types::*;

   logic clock = 0;
   logic reset = 1;
   dsq_if #(.payload_type(req_type)) req (clock);
   dsq_if #(.payload_type(rsp_type)) rsp (clock);

   dedup_sorted_priority_queue dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   initial forever #1 clock = ~clock;

   slot_type queue_model[$];
   rsp_type pending_rsp[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   function automatic rsp_type predict_queue(req_type r);
      rsp_type o;
      int pos;
      bit dup;
      slot_type s;
      o = '0;
      o.status = ST_OK;
      case (op_type'(r.kind))
         OP_ENQ: begin
            pos = 0;
            dup = 0;
            if (queue_model.size() > 0 && r.priority_in > queue_model[0].prio &&
                r.key_in == queue_model[0].key) dup = 1;
            while (pos < queue_model.size() && queue_model[pos].prio >= r.priority_in) begin
               if (queue_model[pos].key == r.key_in) dup = 1;
               pos++;
            end
            if (dup) o.status = ST_DUP;
            else if (queue_model.size() >= DEPTH) o.status = ST_FULL;
            else begin
               s.key = r.key_in;
               s.prio = r.priority_in;
               queue_model.insert(pos, s);
            end
         end
         OP_DEQ: begin
            if (queue_model.size() == 0) o.status = ST_EMPTY;
            else begin
               o.key_out = queue_model[0].key;
               void'(queue_model.pop_front());
            end
         end
         OP_PEEK: begin
            if (queue_model.size() == 0) o.status = ST_EMPTY;
            else o.key_out = queue_model[0].key;
         end
         default: queue_model.delete();
      endcase
      o.empty_res = (queue_model.size() == 0);
      o.full_res = (queue_model.size() >= DEPTH);
      return o;
   endfunction

   task automatic send_op(op_type k, logic [KEY_BITS-1:0] key, logic [PRIORITY_BITS-1:0] pr);
      req_type r;
      r.kind = k;
      r.key_in = key;
      r.priority_in = pr;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.payload <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_rsp.push_back(predict_queue(r));
   endtask

   always @(posedge clock) begin
      rsp.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("Unexpected result %p", rsp.payload);
            end else begin
               if (rsp.payload !== pending_rsp[0]) begin
                  errors++;
                  if (errors <= 10)
                     $display("Mismatch: expected %p actual %p", pending_rsp[0], rsp.payload);
               end
               void'(pending_rsp.pop_front());
            end
         end
      end
   end

   task automatic test_directed();
      send_op(OP_DEQ, '1, '1);
      send_op(OP_PEEK, '0, '0);
      send_op(OP_ENQ, 32'h0, 16'h0);
      send_op(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
      send_op(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
      send_op(OP_ENQ, 32'hFFFF_FFFF, 16'h0);
      send_op(OP_ENQ, 32'h0, 16'hFFFF);
      send_op(OP_PEEK, '0, '0);
      send_op(OP_ENQ, 32'h5, 16'h10);
      send_op(OP_ENQ, 32'h5, 16'h20);
      send_op(OP_DEQ, '0, '0);
      send_op(OP_CLEAR, 32'h1234, 16'h55);
      send_op(OP_ENQ, 32'h7, 16'h3);
      send_op(OP_ENQ, 32'h7, 16'h9);
      send_op(OP_PEEK, '0, '0);
      for (int i = 0; i < 17; i++) send_op(OP_ENQ, 32'h100 + i, 16'(i));
      send_op(OP_ENQ, 32'h100, 16'h0);
      send_op(OP_DEQ, '0, '0);
      send_op(OP_CLEAR, '0, '0);
   endtask

   task automatic test_random(int n);
      int r;
      logic [KEY_BITS-1:0] k;
      logic [PRIORITY_BITS-1:0] p;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         k = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(12));
         p = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(6));
         if (r < 55) send_op(OP_ENQ, k, p);
         else if (r < 80) send_op(OP_DEQ, $urandom(), 16'($urandom()));
         else if (r < 97) send_op(OP_PEEK, $urandom(), 16'($urandom()));
         else send_op(OP_CLEAR, $urandom(), 16'($urandom()));
      end
   endtask

   task automatic drain_results();
      req.valid <= 0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      req.valid <= 0;
      req.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 24;
      recv_idle_pct = 53;
      test_directed();
      test_random(430);
      send_idle_pct = 53;
      recv_idle_pct = 24;
      test_random(430);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(460);
      drain_results();
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ----- dedup_sorted_priority_queue.f -----
hdl/dsq_pkg.sv
hdl/dsq_if.sv
hdl/dedup_sorted_priority_queue.sv
hdl/dsq_checker.sv
tb/sv/tb_dsq_pkg_stub.sv
tb/sv/tb.sv
